[rtl/smdh_pkg.sv]
`timescale 1ns / 1ps

package smdh_pkg;

  localparam int unsigned ROLLS_DEF      = 256;
  localparam int unsigned DIGIT_BASE_DEF = 64;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned BIN_W     = 9;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned CNT_W     = 64;
  localparam int unsigned RATE_W    = 8;
  localparam int unsigned MOD_W     = RATE_W + 1;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned HIST_BINS = 257;

  localparam logic [LEN_W-1:0] MAX_LEN = 9'd256;

  localparam logic [OP_W-1:0] OP_GEN     = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 4'd1;

  localparam logic [RATE_W-1:0] RATE_RST = 8'd65;

  localparam logic [CNT_W-1:0] GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [CNT_W-1:0] MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [CNT_W-1:0] MUL_B = 64'h94d049bb133111eb;
  localparam int unsigned SHIFT_A = 30;
  localparam int unsigned SHIFT_B = 27;
  localparam int unsigned SHIFT_C = 31;

  typedef enum logic [1:0] {
    CMD_GEN,
    CMD_READ,
    CMD_RESTART,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [BIN_W-1:0] bin;
    logic             bin_ok;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROLL,
    ST_DRAIN,
    ST_LOOKUP,
    ST_RESULT
  } back_state_e;

  typedef struct packed {
    logic idle;
    logic rolling;
  } back_stat_t;

endpackage

[rtl/smdh_front.sv]
`timescale 1ns / 1ps

module smdh_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [smdh_pkg::OP_W-1:0]  op_i,
  input  logic [smdh_pkg::BIN_W-1:0] bin_index_i,
  output logic                       cmd_valid_o,
  output smdh_pkg::cmd_t             cmd_o,
  input  logic                       cmd_pop_i
);
  import smdh_pkg::*;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  cmd_t              q_mem_q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  cmd_t              cls;
  logic              push;
  logic              pop;

  // decode the beat into a command for the back end
  always_comb begin
    cls.bin    = bin_index_i;
    cls.bin_ok = bin_index_i < BIN_W'(HIST_BINS);
    case (op_i)
      OP_GEN:     cls.kind = CMD_GEN;
      OP_READ:    cls.kind = CMD_READ;
      OP_RESTART: cls.kind = CMD_RESTART;
      default:    cls.kind = CMD_NOP;
    endcase
  end

  assign in_stall_o  = count_q == QCNT_W'(QDEPTH);
  assign cmd_valid_o = count_q != '0;
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

[rtl/smdh_mix.sv]
`timescale 1ns / 1ps

module smdh_mix #(
  parameter int unsigned DIGIT_BASE = smdh_pkg::DIGIT_BASE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [smdh_pkg::CNT_W-1:0] in_state_i,
  input  logic [smdh_pkg::MOD_W-1:0] modulus_i,
  output logic                       out_valid_o,
  output logic                       out_hit_o
);
  import smdh_pkg::*;

  localparam int unsigned HALF_W     = CNT_W / 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MOD_STAGES = CNT_W / BYTE_W;

  localparam logic [HALF_W-1:0] A_LO = MUL_A[HALF_W-1:0];
  localparam logic [HALF_W-1:0] A_HI = MUL_A[CNT_W-1:HALF_W];
  localparam logic [HALF_W-1:0] B_LO = MUL_B[HALF_W-1:0];
  localparam logic [HALF_W-1:0] B_HI = MUL_B[CNT_W-1:HALF_W];

  // restoring remainder over one byte of the dividend, msb first
  function automatic logic [BYTE_W-1:0] mod_byte(input logic [BYTE_W-1:0] rem,
                                                 input logic [BYTE_W-1:0] bits,
                                                 input logic [MOD_W-1:0]  mm);
    logic [MOD_W-1:0]  acc;
    logic [BYTE_W-1:0] r;
    r = rem;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      acc = {r, bits[i]};
      if (acc >= mm) begin
        acc = acc - mm;
      end
      r = acc[BYTE_W-1:0];
    end
    return r;
  endfunction

  logic              a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, out_v_q;
  logic [CNT_W-1:0]  a_x_q, c_y_q, e_w_q;
  logic [CNT_W-1:0]  b_ll_q, d_ll_q;
  logic [HALF_W-1:0] b_lh_q, b_hl_q, d_lh_q, d_hl_q;
  logic              m_v_q [MOD_STAGES];
  logic [BYTE_W-1:0] m_r_q [MOD_STAGES];
  logic [CNT_W-1:0]  m_w_q [MOD_STAGES];
  logic              hit_q;

  logic [CNT_W-1:0]  z_sum;
  logic [CNT_W-1:0]  p_sum;
  logic [CNT_W-1:0]  q_sum;

  assign z_sum = in_state_i + GAMMA;
  // low 64 bits of a 64x64 product from three 32x32 partials
  assign p_sum = b_ll_q + {b_lh_q + b_hl_q, HALF_W'(0)};
  assign q_sum = d_ll_q + {d_lh_q + d_hl_q, HALF_W'(0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k < MOD_STAGES; k++) begin
        m_v_q[k] <= 1'b0;
      end
    end else begin
      a_v_q    <= in_valid_i;
      b_v_q    <= a_v_q;
      c_v_q    <= b_v_q;
      d_v_q    <= c_v_q;
      e_v_q    <= d_v_q;
      m_v_q[0] <= e_v_q;
      for (int k = 1; k < MOD_STAGES; k++) begin
        m_v_q[k] <= m_v_q[k-1];
      end
      out_v_q  <= m_v_q[MOD_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    a_x_q  <= z_sum ^ (z_sum >> SHIFT_A);
    b_ll_q <= a_x_q[HALF_W-1:0] * A_LO;
    b_lh_q <= a_x_q[HALF_W-1:0] * A_HI;
    b_hl_q <= a_x_q[CNT_W-1:HALF_W] * A_LO;
    c_y_q  <= p_sum ^ (p_sum >> SHIFT_B);
    d_ll_q <= c_y_q[HALF_W-1:0] * B_LO;
    d_lh_q <= c_y_q[HALF_W-1:0] * B_HI;
    d_hl_q <= c_y_q[CNT_W-1:HALF_W] * B_LO;
    e_w_q  <= q_sum ^ (q_sum >> SHIFT_C);
    m_r_q[0] <= mod_byte(BYTE_W'(0), e_w_q[CNT_W-1 -: BYTE_W], modulus_i);
    m_w_q[0] <= e_w_q << BYTE_W;
    for (int k = 1; k < MOD_STAGES; k++) begin
      m_r_q[k] <= mod_byte(m_r_q[k-1], m_w_q[k-1][CNT_W-1 -: BYTE_W], modulus_i);
      m_w_q[k] <= m_w_q[k-1] << BYTE_W;
    end
    hit_q <= {1'b0, m_r_q[MOD_STAGES-1]} < MOD_W'(DIGIT_BASE);
  end

  assign out_valid_o = out_v_q;
  assign out_hit_o   = hit_q;

endmodule

[rtl/smdh_back.sv]
`timescale 1ns / 1ps

module smdh_back #(
  parameter int unsigned ROLLS = smdh_pkg::ROLLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  smdh_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  input  logic [smdh_pkg::CNT_W-1:0] seed_i,
  output logic                       mix_valid_o,
  output logic [smdh_pkg::CNT_W-1:0] mix_state_o,
  input  logic                       mix_valid_i,
  input  logic                       mix_hit_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [smdh_pkg::LEN_W-1:0] seed_len_o,
  output logic [smdh_pkg::CNT_W-1:0] bin_count_o,
  output logic [smdh_pkg::CNT_W-1:0] seeds_total_o,
  output smdh_pkg::back_stat_t       stat_o
);
  import smdh_pkg::*;

  localparam int unsigned ROLL_W = $clog2(ROLLS + 1);
  localparam int unsigned CMP_W  = (ROLL_W > LEN_W) ? ROLL_W : LEN_W;

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  gen_state_q, gen_state_d;
  logic [CNT_W-1:0]  seed_cnt_q, seed_cnt_d;
  logic [ROLL_W-1:0] issued_q, issued_d;
  logic [ROLL_W-1:0] done_q, done_d;
  logic [ROLL_W-1:0] hits_q, hits_d;
  logic [BIN_W-1:0]  addr_q, addr_d;
  logic              gen_q, gen_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  logic [CNT_W-1:0]  res_bin_q, res_bin_d;
  logic [CNT_W-1:0]  res_tot_q, res_tot_d;
  logic              out_v_q, out_v_d;
  logic [LEN_W-1:0]  out_len_q;
  logic [CNT_W-1:0]  out_bin_q;
  logic [CNT_W-1:0]  out_tot_q;

  logic [CNT_W-1:0]     hist_mem [HIST_BINS];
  logic [CNT_W-1:0]     rd_data_q;
  logic [HIST_BINS-1:0] hist_vld_q;

  logic             rd_en;
  logic [BIN_W-1:0] rd_addr;
  logic             wr_en;
  logic             vld_clr;
  logic             vld_set;
  logic             out_load;
  logic [CMP_W-1:0] hits_ext;
  logic [LEN_W-1:0] len_sat;
  logic [CNT_W-1:0] bin_val;
  logic [CNT_W-1:0] bin_inc;

  assign hits_ext = CMP_W'(hits_q);
  assign len_sat  = (hits_ext > CMP_W'(MAX_LEN)) ? MAX_LEN : LEN_W'(hits_ext);
  // a bin never written since restart reads as zero
  assign bin_val  = hist_vld_q[addr_q] ? rd_data_q : '0;
  assign bin_inc  = bin_val + CNT_W'(1);
  assign out_load = (state_q == ST_RESULT) && (!out_v_q || !out_stall_i);
  assign out_v_d  = out_load || (out_v_q && out_stall_i);

  always_comb begin
    state_d     = state_q;
    gen_state_d = gen_state_q;
    seed_cnt_d  = seed_cnt_q;
    issued_d    = issued_q;
    done_d      = done_q;
    hits_d      = hits_q;
    addr_d      = addr_q;
    gen_d       = gen_q;
    res_len_d   = res_len_q;
    res_bin_d   = res_bin_q;
    res_tot_d   = res_tot_q;
    cmd_pop_o   = 1'b0;
    mix_valid_o = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = addr_q;
    wr_en       = 1'b0;
    vld_clr     = 1'b0;
    vld_set     = 1'b0;

    if (mix_valid_i) begin
      done_d = done_q + ROLL_W'(1);
      hits_d = hits_q + ROLL_W'(mix_hit_i);
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_GEN: begin
              issued_d = '0;
              done_d   = '0;
              hits_d   = '0;
              state_d  = ST_ROLL;
            end
            CMD_READ: begin
              if (cmd_i.bin_ok) begin
                rd_en   = 1'b1;
                rd_addr = cmd_i.bin;
                addr_d  = cmd_i.bin;
                gen_d   = 1'b0;
                state_d = ST_LOOKUP;
              end else begin
                res_len_d = '0;
                res_bin_d = '0;
                res_tot_d = seed_cnt_q;
                state_d   = ST_RESULT;
              end
            end
            CMD_RESTART: begin
              vld_clr     = 1'b1;
              seed_cnt_d  = '0;
              gen_state_d = seed_i;
              res_len_d   = '0;
              res_bin_d   = '0;
              res_tot_d   = '0;
              state_d     = ST_RESULT;
            end
            default: begin
              res_len_d = '0;
              res_bin_d = '0;
              res_tot_d = seed_cnt_q;
              state_d   = ST_RESULT;
            end
          endcase
        end
      end
      ST_ROLL: begin
        // one generator step per cycle into the mixing pipeline
        mix_valid_o = 1'b1;
        gen_state_d = gen_state_q + GAMMA;
        issued_d    = issued_q + ROLL_W'(1);
        if (issued_q == ROLL_W'(ROLLS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done_q == ROLL_W'(ROLLS)) begin
          rd_en   = 1'b1;
          rd_addr = len_sat;
          addr_d  = len_sat;
          gen_d   = 1'b1;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (gen_q) begin
          wr_en      = 1'b1;
          vld_set    = 1'b1;
          seed_cnt_d = seed_cnt_q + CNT_W'(1);
          res_len_d  = addr_q;
          res_bin_d  = bin_inc;
          res_tot_d  = seed_cnt_q + CNT_W'(1);
        end else begin
          res_len_d = '0;
          res_bin_d = bin_val;
          res_tot_d = seed_cnt_q;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_state_q <= '0;
      seed_cnt_q  <= '0;
      issued_q    <= '0;
      done_q      <= '0;
      hits_q      <= '0;
      gen_q       <= 1'b0;
      out_v_q     <= 1'b0;
      hist_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      gen_state_q <= gen_state_d;
      seed_cnt_q  <= seed_cnt_d;
      issued_q    <= issued_d;
      done_q      <= done_d;
      hits_q      <= hits_d;
      gen_q       <= gen_d;
      out_v_q     <= out_v_d;
      if (vld_clr) begin
        hist_vld_q <= '0;
      end else if (vld_set) begin
        hist_vld_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    res_len_q <= res_len_d;
    res_bin_q <= res_bin_d;
    res_tot_q <= res_tot_d;
    if (out_load) begin
      out_len_q <= res_len_q;
      out_bin_q <= res_bin_q;
      out_tot_q <= res_tot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_addr];
    end
    if (wr_en) begin
      hist_mem[addr_q] <= bin_inc;
    end
  end

  assign mix_state_o    = gen_state_q;
  assign out_valid_o    = out_v_q;
  assign seed_len_o     = out_len_q;
  assign bin_count_o    = out_bin_q;
  assign seeds_total_o  = out_tot_q;
  assign stat_o.idle    = state_q == ST_IDLE;
  assign stat_o.rolling = (state_q == ST_ROLL) || (state_q == ST_DRAIN);

endmodule

[rtl/splitmix_digit_count_histogram_top.sv]
`timescale 1ns / 1ps

// SplitMix64 seed-length histogram. A generate command (op 0) steps the
// generator ROLLS times at one roll per clock through a 14-stage mixing and
// remainder pipeline. A read is op 1 and a restart op 2. A two-entry command
// queue takes input beats while the back end works, and an output register
// holds a finished result beat while the next command starts. The rate
// register (index 0) and the seed register (index 1) are to be written
// through the config port only while the block is idle; the block itself
// does not enforce this. The seed takes effect at the next restart.
module splitmix_digit_count_histogram_top #(
  parameter int unsigned ROLLS      = smdh_pkg::ROLLS_DEF,
  parameter int unsigned DIGIT_BASE = smdh_pkg::DIGIT_BASE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [smdh_pkg::OP_W-1:0]      op_i,
  input  logic [smdh_pkg::BIN_W-1:0]     bin_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [smdh_pkg::LEN_W-1:0]     seed_len_o,
  output logic [smdh_pkg::CNT_W-1:0]     bin_count_o,
  output logic [smdh_pkg::CNT_W-1:0]     seeds_total_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [smdh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [smdh_pkg::CNT_W-1:0]     cfg_data_i
);
  import smdh_pkg::*;

  logic [RATE_W-1:0] rate_q;
  logic [CNT_W-1:0]  seed_q;
  logic [MOD_W-1:0]  modulus;

  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic             mix_in_valid;
  logic [CNT_W-1:0] mix_in_state;
  logic             mix_out_valid;
  logic             mix_out_hit;
  back_stat_t       back_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RST;
      seed_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_RATE) begin
        rate_q <= cfg_data_i[RATE_W-1:0];
      end
      if (cfg_index_i == CFG_SEED) begin
        seed_q <= cfg_data_i;
      end
    end
  end

  // a rate of zero means a modulus of 256
  assign modulus = (rate_q == '0) ? MOD_W'(1) << RATE_W : {1'b0, rate_q};

  smdh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .bin_index_i (bin_index_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  smdh_mix #(
    .DIGIT_BASE (DIGIT_BASE)
  ) u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mix_in_valid),
    .in_state_i  (mix_in_state),
    .modulus_i   (modulus),
    .out_valid_o (mix_out_valid),
    .out_hit_o   (mix_out_hit)
  );

  smdh_back #(
    .ROLLS (ROLLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .seed_i        (seed_q),
    .mix_valid_o   (mix_in_valid),
    .mix_state_o   (mix_in_state),
    .mix_valid_i   (mix_out_valid),
    .mix_hit_i     (mix_out_hit),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .seed_len_o    (seed_len_o),
    .bin_count_o   (bin_count_o),
    .seeds_total_o (seeds_total_o),
    .stat_o        (back_stat)
  );

`ifndef NO_ASSERTIONS
  a_roll_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mix_in_valid || mix_out_valid) |-> back_stat.rolling)
    else $error("mixing pipeline active outside a generate");

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> (back_stat.idle && cmd_valid))
    else $error("command popped while back end busy or queue empty");

  a_len_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (seed_len_o <= MAX_LEN))
    else $error("seed length above saturation limit");
`endif

endmodule
